@@ hw/rtl/paletted_block_array_unpacker_assert.svh @@
// -----------------------------------------------------------------------------
// Paletted block array unpacker assertion macros
// Shorthand for the concurrent checks that the unpacker keeps on its own logic.
// -----------------------------------------------------------------------------
`ifndef PALETTED_BLOCK_ARRAY_UNPACKER_ASSERT_SVH
`define PALETTED_BLOCK_ARRAY_UNPACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBAU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/pbau_pkg.sv @@
// -----------------------------------------------------------------------------
// Paletted block array unpacker package
// Field widths, command and mode codes and small decode functions.
// -----------------------------------------------------------------------------
package pbau_pkg;

	localparam int CMD_W     = 2;
	localparam int BITS_W    = 5;
	localparam int ID_W      = 31;
	localparam int CHUNK_W   = 22;
	localparam int SECY_W    = 4;
	localparam int WORD_W    = 64;
	localparam int LOCAL_W   = 4;
	localparam int POS_W     = CHUNK_W + LOCAL_W;
	localparam int POSY_W    = SECY_W + LOCAL_W;
	localparam int SLOT_W    = 5;
	localparam int ENTRY_W   = 13;
	localparam int MODE_W    = 2;

	localparam logic [CMD_W-1:0] CMD_HEADER  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PALETTE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DATA    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_SINGLE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PALETTE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DIRECT  = 2'd2;

	localparam logic [BITS_W-1:0] MIN_PALETTE_BITS = 5'd4;
	localparam logic [BITS_W-1:0] MAX_PALETTE_BITS = 5'd8;
	localparam logic [ENTRY_W-1:0] LAST_ENTRY = 13'd4095;

	// Number of whole entries that fit in one 64-bit word, with widths below 4 counted as 4 bits.
	function automatic logic [SLOT_W-1:0] entries_per_word(input logic [BITS_W-1:0] w);
		logic [SLOT_W-1:0] n;
		priority if (w <= 5'd4) begin
			n = 5'd16;
		end else if (w == 5'd5) begin
			n = 5'd12;
		end else if (w == 5'd6) begin
			n = 5'd10;
		end else if (w == 5'd7) begin
			n = 5'd9;
		end else if (w == 5'd8) begin
			n = 5'd8;
		end else if (w == 5'd9) begin
			n = 5'd7;
		end else if (w == 5'd10) begin
			n = 5'd6;
		end else if (w <= 5'd12) begin
			n = 5'd5;
		end else if (w <= 5'd16) begin
			n = 5'd4;
		end else if (w <= 5'd21) begin
			n = 5'd3;
		end else begin
			n = 5'd2;
		end
		return n;
	endfunction

	function automatic logic [ID_W-1:0] entry_mask(input logic [BITS_W-1:0] w);
		return ~({ID_W{1'b1}} << w);
	endfunction

endpackage

@@ hw/rtl/pbau_stream_if.sv @@
// -----------------------------------------------------------------------------
// Paletted block array unpacker channels
// Valid/ready channels for input items and for decoded results.
// -----------------------------------------------------------------------------
interface pbau_in_if import pbau_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic [BITS_W-1:0]         entry_bits;
	logic                      section_nonempty;
	logic [ID_W-1:0]           id_value;
	logic signed [CHUNK_W-1:0] chunk_x;
	logic signed [CHUNK_W-1:0] chunk_z;
	logic [SECY_W-1:0]         section_y;
	logic [WORD_W-1:0]         packed_word;

	modport source (
		output valid, cmd, entry_bits, section_nonempty, id_value,
		output chunk_x, chunk_z, section_y, packed_word,
		input  ready
	);

	modport sink (
		input  valid, cmd, entry_bits, section_nonempty, id_value,
		input  chunk_x, chunk_z, section_y, packed_word,
		output ready
	);
endinterface

interface pbau_out_if import pbau_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ID_W-1:0]         block_id;
	logic signed [POS_W-1:0] pos_x;
	logic [POSY_W-1:0]       pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic                    uniform;
	logic                    palette_fault;
	logic                    last;

	modport source (
		output valid, block_id, pos_x, pos_y, pos_z, uniform, palette_fault, last,
		input  ready
	);

	modport sink (
		input  valid, block_id, pos_x, pos_y, pos_z, uniform, palette_fault, last,
		output ready
	);
endinterface

@@ hw/rtl/paletted_block_array_unpacker.sv @@
// A header's uniform result appears in the cycle after its transfer.
// A data word is unpacked one entry at a time (palette read, then result load, which
// waits for a free output) through one shared shifter and one palette read port.
// Input ready is held low while a word is being unpacked or a result is waiting.
// Reset clears all control state; palette contents stay undefined until written.
// -----------------------------------------------------------------------------
// Paletted block array unpacker
// Decodes headers, palette entries and packed data words of one section into
// block ids with their world positions.
// -----------------------------------------------------------------------------
`include "paletted_block_array_unpacker_assert.svh"

module paletted_block_array_unpacker
	import pbau_pkg::*;
#(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	pbau_in_if.sink    item,
	pbau_out_if.source result
);

	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOOKUP = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;

	logic [1:0]                state_q;
	logic [MODE_W-1:0]         mode_q;
	logic [BITS_W-1:0]         width_q;
	logic [ID_W-1:0]           mask_q;
	logic                      nonempty_q;
	logic [CNT_W-1:0]          pal_count_q;
	logic [ENTRY_W-1:0]        entry_cnt_q;
	logic [CHUNK_W-1:0]        cx_q;
	logic [CHUNK_W-1:0]        cz_q;
	logic [SECY_W-1:0]         sy_q;
	logic [WORD_W-1:0]         word_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [ID_W-1:0]           raw_q;
	logic [ID_W-1:0]           pal_rd_q;
	logic [ID_W-1:0]           pal_mem [PALETTE_DEPTH];

	logic                      out_valid_q;
	logic [ID_W-1:0]           block_id_q;
	logic [POS_W-1:0]          pos_x_q;
	logic [POSY_W-1:0]         pos_y_q;
	logic [POS_W-1:0]          pos_z_q;
	logic                      uniform_q;
	logic                      fault_q;
	logic                      last_q;

	logic                      accept;
	logic                      pal_write;
	logic                      out_free;
	logic                      out_set;
	logic                      emit_fire;
	logic                      emit_last;
	logic                      in_range;
	logic [ID_W-1:0]           raw_next;
	logic [ID_W-1:0]           emit_id;

	assign item.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign accept     = item.valid && item.ready;
	assign pal_write  = accept && (item.cmd == CMD_PALETTE)
		&& (pal_count_q < CNT_W'(PALETTE_DEPTH));
	assign out_free   = !out_valid_q || result.ready;
	assign emit_fire  = (state_q == ST_EMIT) && out_free;
	assign out_set    = emit_fire || (accept && (item.cmd == CMD_HEADER)
		&& (item.entry_bits == '0) && item.section_nonempty);
	assign emit_last  = (slot_q == SLOT_W'(1)) || (entry_cnt_q == LAST_ENTRY);
	assign raw_next   = word_q[ID_W-1:0] & mask_q;
	assign in_range   = raw_q < ID_W'(pal_count_q);

	always_comb begin
		unique case (mode_q)
			MODE_PALETTE: emit_id = in_range ? pal_rd_q : '0;
			default:      emit_id = raw_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pal_write) begin
			pal_mem[pal_count_q[IDX_W-1:0]] <= item.id_value;
		end
		if (state_q == ST_LOOKUP) begin
			pal_rd_q <= pal_mem[raw_next[IDX_W-1:0]];
			raw_q    <= raw_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_SINGLE;
			width_q     <= MIN_PALETTE_BITS;
			mask_q      <= entry_mask(MIN_PALETTE_BITS);
			nonempty_q  <= 1'b0;
			pal_count_q <= '0;
			entry_cnt_q <= '0;
			cx_q        <= '0;
			cz_q        <= '0;
			sy_q        <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && !result.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.cmd)
							CMD_HEADER: begin
								nonempty_q  <= item.section_nonempty;
								cx_q        <= item.chunk_x;
								cz_q        <= item.chunk_z;
								sy_q        <= item.section_y;
								pal_count_q <= '0;
								entry_cnt_q <= '0;
								if (item.entry_bits == '0) begin
									mode_q  <= MODE_SINGLE;
									width_q <= MIN_PALETTE_BITS;
									mask_q  <= entry_mask(MIN_PALETTE_BITS);
								end else if (item.entry_bits <= MAX_PALETTE_BITS) begin
									mode_q <= MODE_PALETTE;
									if (item.entry_bits < MIN_PALETTE_BITS) begin
										width_q <= MIN_PALETTE_BITS;
										mask_q  <= entry_mask(MIN_PALETTE_BITS);
									end else begin
										width_q <= item.entry_bits;
										mask_q  <= entry_mask(item.entry_bits);
									end
								end else begin
									mode_q  <= MODE_DIRECT;
									width_q <= item.entry_bits;
									mask_q  <= entry_mask(item.entry_bits);
								end
							end
							CMD_PALETTE: begin
								if (pal_write) begin
									pal_count_q <= pal_count_q + CNT_W'(1);
								end
							end
							CMD_DATA: begin
								if ((mode_q != MODE_SINGLE) && nonempty_q
									&& !entry_cnt_q[ENTRY_W-1]) begin
									slot_q  <= entries_per_word(width_q);
									state_q <= ST_LOOKUP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_fire) begin
						slot_q      <= slot_q - SLOT_W'(1);
						entry_cnt_q <= entry_cnt_q + ENTRY_W'(1);
						state_q     <= emit_last ? ST_IDLE : ST_LOOKUP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload and the word under decode; the shifter drops one entry per result.
	always_ff @(posedge clk) begin
		if (accept && (item.cmd == CMD_HEADER)) begin
			block_id_q <= item.id_value;
			pos_x_q    <= {item.chunk_x, LOCAL_W'(0)};
			pos_y_q    <= {item.section_y, LOCAL_W'(0)};
			pos_z_q    <= {item.chunk_z, LOCAL_W'(0)};
			uniform_q  <= 1'b1;
			fault_q    <= 1'b0;
			last_q     <= 1'b1;
		end else if (emit_fire) begin
			block_id_q <= emit_id;
			pos_x_q    <= {cx_q, entry_cnt_q[LOCAL_W-1:0]};
			pos_y_q    <= {sy_q, entry_cnt_q[3*LOCAL_W-1:2*LOCAL_W]};
			pos_z_q    <= {cz_q, entry_cnt_q[2*LOCAL_W-1:LOCAL_W]};
			uniform_q  <= 1'b0;
			fault_q    <= (mode_q == MODE_PALETTE) && !in_range;
			last_q     <= emit_last;
		end
		if (accept && (item.cmd == CMD_DATA)) begin
			word_q <= item.packed_word;
		end else if (emit_fire) begin
			word_q <= word_q >> width_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.block_id      = block_id_q;
	assign result.pos_x         = pos_x_q;
	assign result.pos_y         = pos_y_q;
	assign result.pos_z         = pos_z_q;
	assign result.uniform       = uniform_q;
	assign result.palette_fault = fault_q;
	assign result.last          = last_q;

	`PBAU_ASSERT_SAME(a_busy_not_ready, state_q != ST_IDLE, !item.ready,
		"unpacker took an item while busy")
	`PBAU_ASSERT_SAME(a_uniform_last, result.valid && result.uniform,
		result.last && !result.palette_fault, "uniform result must be last and clean")
	`PBAU_ASSERT_SAME(a_fault_zero_id, result.valid && result.palette_fault,
		result.block_id == '0, "faulted result carries a nonzero id")
	`PBAU_ASSERT_SAME(a_count_bound, 1'b1, pal_count_q <= CNT_W'(PALETTE_DEPTH),
		"palette count ran past the store depth")
	`PBAU_ASSERT_NEXT(a_lookup_to_emit, state_q == ST_LOOKUP,
		state_q == ST_EMIT && mode_q != MODE_SINGLE, "lookup not followed by emit")

endmodule
